>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFEF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CFEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cfef_pkg.sv
// Types, constants and helper functions of the contact force error filter.
package cfef_pkg;

    localparam int unsigned ALU_A_W   = 64;
    localparam int unsigned ALU_B_W   = 34;
    localparam int unsigned ALU_R_W   = 66;
    localparam int unsigned MUL_STEPS = 34;
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned SQR_STEPS = 32;

    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [16:0] DT_MIN_US  = 17'd10;
    localparam logic [16:0] DT_MAX_US  = 17'd100000;
    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [18:0] HALF_S_US  = 19'd500000;
    localparam logic [17:0] GAIN_SCALE = 18'd196608;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    localparam logic [2:0] ST_OFF      = 3'd0;
    localparam logic [2:0] ST_NO_FORCE = 3'd1;
    localparam logic [2:0] ST_BAD_DT   = 3'd2;
    localparam logic [2:0] ST_NO_CONT  = 3'd3;
    localparam logic [2:0] ST_STARTED  = 3'd4;
    localparam logic [2:0] ST_RUNNING  = 3'd5;

    localparam logic [1:0] REG_CONTACT_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_NORMAL_SMOOTHING  = 2'd1;
    localparam logic [1:0] REG_FLIP_FORCE        = 2'd2;

    typedef enum logic [2:0] {
        ALU_MUL  = 3'b001,
        ALU_DIV  = 3'b010,
        ALU_SQRT = 3'b100
    } t_alu_op;

    typedef struct packed {
        logic                 start;
        t_alu_op              op;
        logic [ALU_A_W-1:0]   a;
        logic [ALU_B_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic                 done;
        logic [ALU_R_W-1:0]   res;
    } t_alu_rsp;

    function automatic logic [31:0] f_mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Divide by 2^16, rounding to nearest with ties away from zero.
    function automatic logic signed [65:0] f_rnd16(input logic signed [65:0] v);
        logic [65:0] m;
        logic [65:0] q;
        m = v[65] ? 66'(-v) : 66'(v);
        q = (m + 66'd32768) >> 16;
        return v[65] ? -$signed(q) : $signed(q);
    endfunction

    // Divide by 2^30, rounding to nearest with ties away from zero.
    function automatic logic signed [65:0] f_rnd30(input logic signed [65:0] v);
        logic [65:0] m;
        logic [65:0] q;
        m = v[65] ? 66'(-v) : 66'(v);
        q = (m + 66'd536870912) >> 30;
        return v[65] ? -$signed(q) : $signed(q);
    endfunction

endpackage

>>> hdl/cfef_alu.sv
// Bit-serial multiplier, restoring divider and square root sharing one datapath.
module cfef_alu
    import cfef_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    t_alu_op       r_op, n_op;
    logic [6:0]    r_cnt, n_cnt;
    logic [65:0]   r_sa, n_sa;
    logic [33:0]   r_sb, n_sb;
    logic [65:0]   r_acc, n_acc;
    logic [63:0]   r_q, n_q;

    logic [32:0]   rem_div;
    logic [34:0]   rem_sqr;
    logic [34:0]   trial;

    assign rem_div = {r_acc[31:0], r_sa[63]};
    assign rem_sqr = {r_acc[32:0], r_sa[63:62]};
    assign trial   = {1'b0, r_q[31:0], 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_sa   = r_sa;
        n_sb   = r_sb;
        n_acc  = r_acc;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_sa   = {2'b00, i_req.a};
            n_sb   = i_req.b;
            n_acc  = '0;
            n_q    = '0;
            case (i_req.op)
                ALU_MUL:  n_cnt = 7'(MUL_STEPS);
                ALU_DIV:  n_cnt = 7'(DIV_STEPS);
                ALU_SQRT: n_cnt = 7'(SQR_STEPS);
                default:  n_cnt = 7'(MUL_STEPS);
            endcase
        end else if (r_busy) begin
            case (r_op)
                ALU_MUL: begin
                    if (r_sb[0]) n_acc = r_acc + r_sa;
                    n_sa = r_sa << 1;
                    n_sb = r_sb >> 1;
                end
                ALU_DIV: begin
                    if (rem_div >= {1'b0, r_sb[31:0]}) begin
                        n_acc = {33'b0, rem_div - {1'b0, r_sb[31:0]}};
                        n_q   = {r_q[62:0], 1'b1};
                    end else begin
                        n_acc = {33'b0, rem_div};
                        n_q   = {r_q[62:0], 1'b0};
                    end
                    n_sa = r_sa << 1;
                end
                ALU_SQRT: begin
                    if (rem_sqr >= trial) begin
                        n_acc = {31'b0, rem_sqr - trial};
                        n_q   = {r_q[62:0], 1'b1};
                    end else begin
                        n_acc = {31'b0, rem_sqr};
                        n_q   = {r_q[62:0], 1'b0};
                    end
                    n_sa = r_sa << 2;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_acc <= n_acc;
        r_q   <= n_q;
    end

    always_comb begin
        o_rsp.done = r_done;
        case (r_op)
            ALU_MUL:  o_rsp.res = r_acc;
            ALU_DIV:  o_rsp.res = {2'b00, r_q};
            ALU_SQRT: o_rsp.res = {34'b0, r_q[31:0]};
            default:  o_rsp.res = '0;
        endcase
    end

endmodule

>>> hdl/contact_force_error_filter.sv
// Top level of the contact force error filter: tick sequencer and state.
//
//  channel  direction  handshake                    payload
//  in       input      i_in_valid / o_in_ready      force, target, interval, flags
//  out      output     o_out_valid / i_out_ready    status, error, rates, normal
//  cfg      input      i_cfg_valid / o_cfg_ready    register index, data
//
// Mode off, no force yet and a bad interval go straight to the final step; a force below the
// threshold ends after the squared-magnitude check. A full tick runs its multiplies, divides
// and square root one at a time on the shared bit-serial unit, each with issue and handoff,
// plus normalizing shifts per pass; blending a known normal adds a second normalizing pass.
// Reset is synchronous and active low and restores the filter state and registers.
// A new input beat is taken while the previous result waits on the output.
`include "assert_macros.svh"
module contact_force_error_filter
    import cfef_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_force_z,
    input  logic signed [31:0] i_force_target,
    input  logic [16:0]        i_interval_us,
    input  logic               i_admittance_on,
    input  logic               i_force_seen,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_force_error,
    output logic signed [31:0] o_error_rate_raw,
    output logic signed [31:0] o_error_rate_filtered,
    output logic signed [31:0] o_unit_normal_x,
    output logic signed [31:0] o_unit_normal_y,
    output logic signed [31:0] o_unit_normal_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001, S_SQ   = 20'h00002, S_TH   = 20'h00004, S_NCHK = 20'h00008,
        S_NSQ  = 20'h00010, S_NRT  = 20'h00020, S_NDV  = 20'h00040, S_NRET = 20'h00080,
        S_BLM  = 20'h00100, S_BLR  = 20'h00200, S_CHK  = 20'h00400, S_DOT  = 20'h00800,
        S_ERR  = 20'h01000, S_GMUL = 20'h02000, S_GDIV = 20'h04000, S_RMUL = 20'h08000,
        S_RDIV = 20'h10000, S_FMUL = 20'h20000, S_FRND = 20'h40000, S_FIN  = 20'h80000
    } t_state;

    t_state             r_state, n_state;
    logic               r_wait, n_wait;
    logic [1:0]         r_idx, n_idx;
    logic               r_sub, n_sub;
    logic               r_pass, n_pass;
    logic               r_fail, n_fail;
    logic signed [31:0] r_f [3];
    logic signed [31:0] n_f [3];
    logic signed [31:0] r_target, n_target;
    logic [16:0]        r_us, n_us;
    logic [31:0]        r_m [3];
    logic [31:0]        n_m [3];
    logic               r_neg [3];
    logic               n_neg [3];
    logic signed [31:0] r_q [3];
    logic signed [31:0] n_q [3];
    logic signed [31:0] r_nn [3];
    logic signed [31:0] n_nn [3];
    logic signed [31:0] r_nvec [3];
    logic signed [31:0] n_nvec [3];
    logic               r_known, n_known;
    logic               r_started, n_started;
    logic signed [31:0] r_last_err, n_last_err;
    logic signed [31:0] r_last_filt, n_last_filt;
    logic signed [65:0] r_acc, n_acc;
    logic [31:0]        r_root, n_root;
    logic [16:0]        r_gain, n_gain;
    logic [2:0]         r_stat, n_stat;
    logic signed [31:0] r_err, n_err;
    logic signed [31:0] r_raw, n_raw;
    logic signed [31:0] r_filt, n_filt;
    logic [16:0]        r_th, n_th;
    logic [16:0]        r_sm, n_sm;
    logic               r_flip, n_flip;
    logic               r_o_valid, n_o_valid;
    logic [2:0]         r_o_status;
    logic signed [31:0] r_o_err, r_o_raw, r_o_filt;
    logic signed [31:0] r_o_n [3];
    logic               load_out;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    logic               alu_state;
    logic               go;
    logic               prod_neg;
    logic [16:0]        a_eff;
    logic [16:0]        a_inv;
    logic [16:0]        g_inv;
    logic signed [65:0] acc_sum;
    logic signed [65:0] blend;
    logic [65:0]        blend_mag;
    logic signed [65:0] err_wide;
    logic signed [33:0] diff;
    logic [33:0]        diff_mag;
    logic signed [65:0] raw_wide;
    logic [31:0]        qv;
    logic               m_any31;
    logic               m_any30;
    logic               m_zero;
    logic               q_zero;
    logic               bad_dt;

    cfef_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign alu_state = (r_state == S_SQ) || (r_state == S_TH) || (r_state == S_NSQ) ||
                       (r_state == S_NRT) || (r_state == S_NDV) || (r_state == S_BLM) ||
                       (r_state == S_DOT) || (r_state == S_GMUL) || (r_state == S_GDIV) ||
                       (r_state == S_RMUL) || (r_state == S_RDIV) || (r_state == S_FMUL);
    assign go        = r_wait && alu_rsp.done;

    assign a_eff     = (r_sm > ONE_Q16) ? ONE_Q16 : r_sm;
    assign a_inv     = ONE_Q16 - a_eff;
    assign g_inv     = ONE_Q16 - r_gain;
    assign acc_sum   = prod_neg ? r_acc - $signed(alu_rsp.res) : r_acc + $signed(alu_rsp.res);
    assign blend     = f_rnd16(r_acc);
    assign blend_mag = blend[65] ? 66'(-blend) : 66'(blend);
    assign err_wide  = {{34{r_target[31]}}, r_target} - f_rnd30(r_acc);
    assign diff      = {{2{r_err[31]}}, r_err} - {{2{r_last_err[31]}}, r_last_err};
    assign diff_mag  = diff[33] ? 34'(-diff) : 34'(diff);
    assign raw_wide  = diff[33] ? -$signed(alu_rsp.res) : $signed(alu_rsp.res);
    assign qv        = alu_rsp.res[31:0];
    assign m_any31   = r_m[0][31] | r_m[1][31] | r_m[2][31];
    assign m_any30   = r_m[0][30] | r_m[1][30] | r_m[2][30];
    assign m_zero    = (r_m[0] == 32'd0) && (r_m[1] == 32'd0) && (r_m[2] == 32'd0);
    assign q_zero    = (r_q[0] == 32'sd0) && (r_q[1] == 32'sd0) && (r_q[2] == 32'sd0);
    assign bad_dt    = (i_interval_us <= DT_MIN_US) || (i_interval_us > DT_MAX_US);

    always_comb begin
        case (r_state)
            S_BLM:   prod_neg = r_sub ? r_nn[r_idx][31] : r_nvec[r_idx][31];
            S_DOT:   prod_neg = r_q[r_idx][31] ^ r_f[r_idx][31] ^ r_flip;
            S_FMUL:  prod_neg = r_sub ? r_raw[31] : r_last_filt[31];
            default: prod_neg = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_wait      = alu_state && !go;
        n_idx       = r_idx;
        n_sub       = r_sub;
        n_pass      = r_pass;
        n_fail      = r_fail;
        n_f         = r_f;
        n_target    = r_target;
        n_us        = r_us;
        n_m         = r_m;
        n_neg       = r_neg;
        n_q         = r_q;
        n_nn        = r_nn;
        n_nvec      = r_nvec;
        n_known     = r_known;
        n_started   = r_started;
        n_last_err  = r_last_err;
        n_last_filt = r_last_filt;
        n_acc       = r_acc;
        n_root      = r_root;
        n_gain      = r_gain;
        n_stat      = r_stat;
        n_err       = r_err;
        n_raw       = r_raw;
        n_filt      = r_filt;
        load_out    = 1'b0;

        alu_req.start = alu_state && !r_wait;
        alu_req.op    = ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_f[0]   = i_force_x;
                    n_f[1]   = i_force_y;
                    n_f[2]   = i_force_z;
                    n_target = i_force_target;
                    n_us     = i_interval_us;
                    n_err    = '0;
                    n_raw    = '0;
                    n_filt   = '0;
                    n_acc    = '0;
                    n_idx    = 2'd0;
                    if (!i_admittance_on) begin
                        n_stat    = ST_OFF;
                        n_started = 1'b0;
                        n_state   = S_FIN;
                    end else if (!i_force_seen) begin
                        n_stat  = ST_NO_FORCE;
                        n_state = S_FIN;
                    end else if (bad_dt) begin
                        n_stat    = ST_BAD_DT;
                        n_started = 1'b0;
                        n_state   = S_FIN;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                alu_req.a = {32'b0, f_mag32(r_f[r_idx])};
                alu_req.b = {2'b0, f_mag32(r_f[r_idx])};
                if (go) begin
                    n_acc = acc_sum;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd2) n_state = S_TH;
                end
            end
            S_TH: begin
                alu_req.a = {47'b0, r_th};
                alu_req.b = {17'b0, r_th};
                if (go) begin
                    if ($unsigned(r_acc) < alu_rsp.res) begin
                        n_stat    = ST_NO_CONT;
                        n_started = 1'b0;
                        n_state   = S_FIN;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            n_m[i]   = f_mag32(r_f[i]);
                            n_neg[i] = r_f[i][31];
                        end
                        n_pass  = 1'b0;
                        n_state = S_NCHK;
                    end
                end
            end
            S_NCHK: begin
                if (m_zero) begin
                    n_fail  = 1'b1;
                    n_state = S_NRET;
                end else if (m_any31) begin
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] >> 1;
                end else if (!m_any30) begin
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] << 1;
                end else begin
                    n_acc   = '0;
                    n_idx   = 2'd0;
                    n_state = S_NSQ;
                end
            end
            S_NSQ: begin
                alu_req.a = {32'b0, r_m[r_idx]};
                alu_req.b = {2'b0, r_m[r_idx]};
                if (go) begin
                    n_acc = acc_sum;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd2) n_state = S_NRT;
                end
            end
            S_NRT: begin
                alu_req.op = ALU_SQRT;
                alu_req.a  = r_acc[63:0];
                if (go) begin
                    n_root  = alu_rsp.res[31:0];
                    n_idx   = 2'd0;
                    n_state = S_NDV;
                end
            end
            S_NDV: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = {2'b0, r_m[r_idx], 30'b0} + {33'b0, r_root[31:1]};
                alu_req.b  = {2'b0, r_root};
                if (go) begin
                    n_q[r_idx] = r_neg[r_idx] ? -$signed(qv) : $signed(qv);
                    n_idx      = r_idx + 2'd1;
                    if (r_idx == 2'd2) begin
                        n_fail  = 1'b0;
                        n_state = S_NRET;
                    end
                end
            end
            S_NRET: begin
                n_fail = 1'b0;
                if (!r_pass) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_fail) n_nn[i] = '0;
                        else n_nn[i] = r_flip ? -r_q[i] : r_q[i];
                    end
                    if (!r_known) begin
                        n_q     = n_nn;
                        n_state = S_CHK;
                    end else begin
                        n_acc   = '0;
                        n_idx   = 2'd0;
                        n_sub   = 1'b0;
                        n_state = S_BLM;
                    end
                end else begin
                    if (r_fail) n_q = r_nn;
                    n_state = S_CHK;
                end
            end
            S_BLM: begin
                alu_req.a = r_sub ? {47'b0, a_eff} : {47'b0, a_inv};
                alu_req.b = r_sub ? {2'b0, f_mag32(r_nn[r_idx])} : {2'b0, f_mag32(r_nvec[r_idx])};
                if (go) begin
                    n_acc = acc_sum;
                    n_sub = !r_sub;
                    if (r_sub) n_state = S_BLR;
                end
            end
            S_BLR: begin
                n_m[r_idx]   = blend_mag[31:0];
                n_neg[r_idx] = blend[65];
                n_acc        = '0;
                n_idx        = r_idx + 2'd1;
                if (r_idx == 2'd2) begin
                    n_pass  = 1'b1;
                    n_state = S_NCHK;
                end else begin
                    n_state = S_BLM;
                end
            end
            S_CHK: begin
                if (q_zero) begin
                    n_stat    = ST_NO_CONT;
                    n_started = 1'b0;
                    n_state   = S_FIN;
                end else begin
                    n_nvec  = r_q;
                    n_known = 1'b1;
                    n_acc   = '0;
                    n_idx   = 2'd0;
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                alu_req.a = {32'b0, f_mag32(r_q[r_idx])};
                alu_req.b = {2'b0, f_mag32(r_f[r_idx])};
                if (go) begin
                    n_acc = acc_sum;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd2) n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_err = f_sat32(err_wide);
                if (!r_started) begin
                    n_last_err  = f_sat32(err_wide);
                    n_last_filt = '0;
                    n_started   = 1'b1;
                    n_stat      = ST_STARTED;
                    n_state     = S_FIN;
                end else begin
                    n_state = S_GMUL;
                end
            end
            S_GMUL: begin
                alu_req.a = {47'b0, r_us};
                alu_req.b = {16'b0, GAIN_SCALE};
                if (go) begin
                    n_acc   = $signed(alu_rsp.res);
                    n_state = S_GDIV;
                end
            end
            S_GDIV: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = r_acc[63:0] + {45'b0, HALF_S_US};
                alu_req.b  = {14'b0, US_PER_S};
                if (go) begin
                    n_gain  = (alu_rsp.res > {49'b0, ONE_Q16}) ? ONE_Q16 : alu_rsp.res[16:0];
                    n_state = S_RMUL;
                end
            end
            S_RMUL: begin
                alu_req.a = {44'b0, US_PER_S};
                alu_req.b = diff_mag;
                if (go) begin
                    n_acc   = $signed(alu_rsp.res);
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = r_acc[63:0] + {48'b0, r_us[16:1]};
                alu_req.b  = {17'b0, r_us};
                if (go) begin
                    n_raw   = f_sat32(raw_wide);
                    n_acc   = '0;
                    n_sub   = 1'b0;
                    n_state = S_FMUL;
                end
            end
            S_FMUL: begin
                alu_req.a = r_sub ? {47'b0, r_gain} : {47'b0, g_inv};
                alu_req.b = r_sub ? {2'b0, f_mag32(r_raw)} : {2'b0, f_mag32(r_last_filt)};
                if (go) begin
                    n_acc = acc_sum;
                    n_sub = !r_sub;
                    if (r_sub) n_state = S_FRND;
                end
            end
            S_FRND: begin
                n_filt      = f_sat32(blend);
                n_last_filt = f_sat32(blend);
                n_last_err  = r_err;
                n_stat      = ST_RUNNING;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_o_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_th   = r_th;
        n_sm   = r_sm;
        n_flip = r_flip;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CONTACT_THRESHOLD: n_th   = i_cfg_data;
                REG_NORMAL_SMOOTHING:  n_sm   = i_cfg_data;
                REG_FLIP_FORCE:        n_flip = i_cfg_data[0];
                default: begin
                    n_flip = r_flip;
                end
            endcase
        end
    end

    assign n_o_valid = load_out || (r_o_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_o_valid   <= 1'b0;
            r_known     <= 1'b0;
            r_started   <= 1'b0;
            r_last_err  <= '0;
            r_last_filt <= '0;
            r_nvec[0]   <= ONE_Q30;
            r_nvec[1]   <= '0;
            r_nvec[2]   <= '0;
            r_th        <= 17'd328;
            r_sm        <= 17'd13107;
            r_flip      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_o_valid   <= n_o_valid;
            r_known     <= n_known;
            r_started   <= n_started;
            r_last_err  <= n_last_err;
            r_last_filt <= n_last_filt;
            r_nvec      <= n_nvec;
            r_th        <= n_th;
            r_sm        <= n_sm;
            r_flip      <= n_flip;
        end
        r_idx    <= n_idx;
        r_sub    <= n_sub;
        r_pass   <= n_pass;
        r_fail   <= n_fail;
        r_f      <= n_f;
        r_target <= n_target;
        r_us     <= n_us;
        r_m      <= n_m;
        r_neg    <= n_neg;
        r_q      <= n_q;
        r_nn     <= n_nn;
        r_acc    <= n_acc;
        r_root   <= n_root;
        r_gain   <= n_gain;
        r_stat   <= n_stat;
        r_err    <= n_err;
        r_raw    <= n_raw;
        r_filt   <= n_filt;
        if (load_out) begin
            r_o_status <= r_stat;
            r_o_err    <= r_err;
            r_o_raw    <= r_raw;
            r_o_filt   <= r_filt;
            r_o_n      <= r_nvec;
        end
    end

    assign o_out_valid           = r_o_valid;
    assign o_status              = r_o_status;
    assign o_force_error         = r_o_err;
    assign o_error_rate_raw      = r_o_raw;
    assign o_error_rate_filtered = r_o_filt;
    assign o_unit_normal_x       = r_o_n[0];
    assign o_unit_normal_y       = r_o_n[1];
    assign o_unit_normal_z       = r_o_n[2];

    `CFEF_ASSERT_NEXT(a_out_from_fin, !r_o_valid && n_o_valid, r_state == S_IDLE, "result beat loaded outside the final step")
    `CFEF_ASSERT_NOW(a_status_range, o_out_valid, o_status <= ST_RUNNING, "status code out of range")
    `CFEF_ASSERT_NOW(a_early_zero, o_out_valid && (o_status < ST_STARTED), (o_force_error == 32'sd0) && (o_error_rate_raw == 32'sd0) && (o_error_rate_filtered == 32'sd0), "early exit with nonzero result")
    `CFEF_ASSERT_NOW(a_normal_range, o_out_valid, (o_unit_normal_x <= ONE_Q30) && (o_unit_normal_x >= -ONE_Q30) && (o_unit_normal_z <= ONE_Q30) && (o_unit_normal_z >= -ONE_Q30), "unit normal beyond one")

endmodule
